@@ rtl/socc_pkg.sv @@
// Shared types and constants for the subarray OR coverage checker.
// No dependencies; imported by every module of the block.
package socc_pkg;

  localparam int MAX_WIDTH_DEF  = 16;
  localparam int LIST_DEPTH_DEF = 17;
  localparam int IN_W           = 16;
  localparam int CFG_W          = 5;
  localparam logic [CFG_W-1:0] WIDTH_RESET = 5'd16;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Broadcast to every cell of the list chain.
  typedef struct packed {
    logic pop;
    logic push;
  } cell_ctl_t;

endpackage

@@ rtl/socc_cell.sv @@
// One cell of the run-OR list chain: holds one entry, shifts toward the head
// on pop and loads the pushed value when it is the tail slot. Uses socc_pkg.
module socc_cell #(
  parameter int DATA_W = socc_pkg::MAX_WIDTH_DEF,
  parameter int CNT_W  = 5,
  parameter int IDX    = 0
) (
  input  logic                 clk,
  input  socc_pkg::cell_ctl_t  ctl,
  input  logic [CNT_W-1:0]     len_post,
  input  logic [DATA_W-1:0]    push_data,
  input  logic [DATA_W-1:0]    right_val,
  output logic [DATA_W-1:0]    val
);
  import socc_pkg::*;

  logic [DATA_W-1:0] val_r;

  // len_post is the occupancy after this cycle's pop, i.e. the tail slot.
  always_ff @(posedge clk) begin
    if (ctl.push && len_post == CNT_W'(IDX)) begin
      val_r <= push_data;
    end else if (ctl.pop) begin
      val_r <= right_val;
    end
  end

  assign val = val_r;

endmodule

@@ rtl/socc_bitmap.sv @@
// Single-bit seen bitmap: one write and one registered read per cycle.
// Read returns the old contents when the same address is written.
module socc_bitmap #(
  parameter int AW = socc_pkg::MAX_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic          wdata,
  input  logic [AW-1:0] raddr,
  output logic          rdata
);
  import socc_pkg::*;

  logic mem [2**AW];
  logic rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/subarray_or_coverage_check.sv @@
// Subarray OR coverage checker, top level. Uses socc_pkg, socc_cell, socc_bitmap.
//
// Input: a transaction is taken when start is high and busy is low. It carries
// one mask value (bits at or above the effective width are dropped) and a
// last-item flag. The effective width is cfg_wdata as last written through
// cfg_we, clamped to 1..MAX_WIDTH; reset value 16.
// Each item pops the stored run ORs one per cycle from the head of a chain of
// LIST_DEPTH cells, ORs them with the new value and pushes the distinct ones
// back at the tail, marking each pushed value in the seen bitmap. Busy stays
// high while the list is walked (its length is at most LIST_DEPTH); the single
// bitmap write port sets that pace.
// On a last item the bitmap is swept once over 2^maxw entries, maxw being the
// largest width used in the sequence: entries 1 to the current mask are checked and
// every entry is cleared, one per cycle. out_strobe then pulses for one cycle with
// out_all_covered, and busy drops in that same cycle. No result for other items.
// Reset: a clearing pass writes all 2^MAX_WIDTH bitmap entries, one per cycle,
// with busy high; configuration writes are taken during it.
// The result cannot be held off by the receiver.
module subarray_or_coverage_check #(
  parameter int MAX_WIDTH  = socc_pkg::MAX_WIDTH_DEF,
  parameter int LIST_DEPTH = socc_pkg::LIST_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [socc_pkg::IN_W-1:0]  in_mask_value,
  input  logic                       in_last_item,
  output logic                       out_strobe,
  output logic                       out_all_covered,
  input  logic                       cfg_we,
  input  logic [socc_pkg::CFG_W-1:0] cfg_wdata
);
  import socc_pkg::*;

  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int WW    = $clog2(MAX_WIDTH + 1);

  state_t                 state_r, state_nxt;
  logic [CFG_W-1:0]       width_r;
  logic [MAX_WIDTH-1:0]   v_r, v_nxt;
  logic [MAX_WIDTH-1:0]   m_r, m_nxt;
  logic                   last_r, last_nxt;
  logic [MAX_WIDTH-1:0]   pend_r, pend_nxt;
  logic [CNT_W-1:0]       pops_r, pops_nxt;
  logic [CNT_W-1:0]       pushed_r, pushed_nxt;
  logic [CNT_W-1:0]       len_r, len_nxt, len_post;
  logic [WW-1:0]          maxw_r, maxw_nxt;
  logic [MAX_WIDTH-1:0]   addr_r, addr_nxt;
  logic                   chk_vld_r, chk_vld_nxt;
  logic                   all_r, all_nxt;
  logic                   out_strobe_r, out_strobe_nxt;
  logic                   out_cov_r, out_cov_nxt;

  logic [WW-1:0]          eff_w;
  logic [MAX_WIDTH-1:0]   eff_mask;
  logic [MAX_WIDTH-1:0]   in_ext;
  logic [MAX_WIDTH-1:0]   end_addr;
  logic [MAX_WIDTH-1:0]   run_x;

  cell_ctl_t              ctl;
  logic [MAX_WIDTH-1:0]   cell_val [LIST_DEPTH];

  logic                   mem_we;
  logic [MAX_WIDTH-1:0]   mem_waddr;
  logic                   mem_wdata;
  logic                   mem_rdata;

  // Width clamp: zero acts as one, anything above MAX_WIDTH as MAX_WIDTH.
  always_comb begin
    if (width_r == '0) begin
      eff_w = WW'(1);
    end else if (32'(width_r) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(width_r);
    end
  end

  assign eff_mask = ~({MAX_WIDTH{1'b1}} << eff_w);
  assign end_addr = ~({MAX_WIDTH{1'b1}} << maxw_r);
  assign in_ext   = MAX_WIDTH'(in_mask_value);
  assign run_x    = (cell_val[0] | v_r) & m_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      width_r      <= WIDTH_RESET;
      pops_r       <= '0;
      pushed_r     <= '0;
      len_r        <= '0;
      maxw_r       <= '0;
      addr_r       <= '0;
      chk_vld_r    <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      if (cfg_we) begin
        width_r <= cfg_wdata;
      end
      pops_r       <= pops_nxt;
      pushed_r     <= pushed_nxt;
      len_r        <= len_nxt;
      maxw_r       <= maxw_nxt;
      addr_r       <= addr_nxt;
      chk_vld_r    <= chk_vld_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r       <= v_nxt;
    m_r       <= m_nxt;
    last_r    <= last_nxt;
    pend_r    <= pend_nxt;
    all_r     <= all_nxt;
    out_cov_r <= out_cov_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    v_nxt          = v_r;
    m_nxt          = m_r;
    last_nxt       = last_r;
    pend_nxt       = pend_r;
    pops_nxt       = pops_r;
    pushed_nxt     = pushed_r;
    maxw_nxt       = maxw_r;
    addr_nxt       = addr_r;
    chk_vld_nxt    = 1'b0;
    all_nxt        = all_r;
    out_strobe_nxt = 1'b0;
    out_cov_nxt    = out_cov_r;
    ctl            = '0;
    mem_we         = 1'b0;
    mem_waddr      = addr_r;
    mem_wdata      = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        mem_we   = 1'b1;
        addr_nxt = addr_r + 1'b1;
        if (addr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (start) begin
          v_nxt      = in_ext & eff_mask;
          pend_nxt   = in_ext & eff_mask;
          m_nxt      = eff_mask;
          last_nxt   = in_last_item;
          pops_nxt   = len_r;
          pushed_nxt = '0;
          if (eff_w > maxw_r) begin
            maxw_nxt = eff_w;
          end
          state_nxt  = ST_RUN;
        end
      end

      ST_RUN: begin
        // pend_r holds the newest distinct OR, pushed once a different one shows up or the pops are done
        if (pops_r != '0) begin
          ctl.pop  = 1'b1;
          pops_nxt = pops_r - 1'b1;
          if (run_x != pend_r) begin
            pend_nxt = run_x;
            ctl.push = (pushed_r < CNT_W'(LIST_DEPTH));
          end
        end else begin
          ctl.push = (pushed_r < CNT_W'(LIST_DEPTH));
          if (last_r) begin
            state_nxt = ST_SCAN;
            addr_nxt  = '0;
            all_nxt   = 1'b1;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
        if (ctl.push) begin
          pushed_nxt = pushed_r + 1'b1;
          mem_we     = 1'b1;
          mem_waddr  = pend_r;
          mem_wdata  = 1'b1;
        end
      end

      ST_SCAN: begin
        // check 1..mask, clear everything up to the sequence's widest range
        mem_we      = 1'b1;
        chk_vld_nxt = (addr_r != '0) && (addr_r <= m_r);
        if (chk_vld_r && !mem_rdata) begin
          all_nxt = 1'b0;
        end
        addr_nxt = addr_r + 1'b1;
        if (addr_r == end_addr) begin
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        out_strobe_nxt = 1'b1;
        out_cov_nxt    = all_r & (!chk_vld_r | mem_rdata);
        maxw_nxt       = '0;
        state_nxt      = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    len_post = len_r - CNT_W'(ctl.pop);
    len_nxt  = (state_r == ST_DONE) ? '0 : len_post + CNT_W'(ctl.push);
  end

  for (genvar k = 0; k < LIST_DEPTH; k++) begin : g_cell
    logic [MAX_WIDTH-1:0] right_val;
    if (k == LIST_DEPTH - 1) begin : g_tail
      assign right_val = '0;
    end else begin : g_mid
      assign right_val = cell_val[k+1];
    end

    socc_cell #(
      .DATA_W (MAX_WIDTH),
      .CNT_W  (CNT_W),
      .IDX    (k)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .len_post  (len_post),
      .push_data (pend_r),
      .right_val (right_val),
      .val       (cell_val[k])
    );
  end

  socc_bitmap #(
    .AW (MAX_WIDTH)
  ) u_bitmap (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (addr_r),
    .rdata (mem_rdata)
  );

  assign busy            = (state_r != ST_IDLE);
  assign out_strobe      = out_strobe_r;
  assign out_all_covered = out_cov_r;

  a_strobe_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> $past(state_r == ST_DONE))
    else $error("result strobe without a finished sweep");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= CNT_W'(LIST_DEPTH))
    else $error("list occupancy beyond depth");

  a_accept_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == ST_RUN))
    else $error("accepted transaction did not start processing");

  a_mark_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.push |-> ((pend_r & ~m_r) == '0))
    else $error("marked value outside the active width");

endmodule

@@ verif/coverage_result_checker.sv @@
// Checker for subarray_or_coverage_check: keeps its own run-OR list and seen bitmap,
// predicts all_covered for every last-item transaction and compares it with out_all_covered at out_strobe.
// Depends on socc_pkg for port widths and the register reset value.
module coverage_result_checker #(
  parameter int MAX_WIDTH  = socc_pkg::MAX_WIDTH_DEF,
  parameter int LIST_DEPTH = socc_pkg::LIST_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  logic [socc_pkg::IN_W-1:0]  in_mask_value,
  input  logic                       in_last_item,
  input  logic                       out_strobe,
  input  logic                       out_all_covered,
  input  logic                       cfg_we,
  input  logic [socc_pkg::CFG_W-1:0] cfg_wdata,
  output int                         mismatches,
  output int                         outstanding
);
  import socc_pkg::*;

  logic [CFG_W-1:0] width_reg;
  logic [IN_W-1:0]  or_list [LIST_DEPTH];
  int               or_count;
  int               seq_max_w;
  // Starts cleared; nothing can be marked before reset is released.
  bit               seen [2**MAX_WIDTH];
  bit               covered_q [$];

  task automatic flag_failure(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $time, msg);
  endtask

  // Folds one mask into the run-OR list; on the last item queues the coverage verdict.
  task automatic fold_mask(input logic [IN_W-1:0] raw, input logic last);
    int              w;
    int              n;
    int unsigned     m;
    logic [IN_W-1:0] lowmask;
    logic [IN_W-1:0] v;
    logic [IN_W-1:0] x;
    logic [IN_W-1:0] next_list [LIST_DEPTH];
    bit              hit_all;
    w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg));
    m = (1 << w) - 1;
    lowmask = IN_W'(m);
    v = raw & lowmask;
    next_list[0] = v;
    n = 1;
    // older entries get masked to the current width as they are folded
    for (int i = 0; i < or_count; i++) begin
      x = (or_list[i] | v) & lowmask;
      if (x != next_list[n-1] && n < LIST_DEPTH) begin
        next_list[n] = x;
        n++;
      end
    end
    for (int i = 0; i < n; i++) begin
      or_list[i] = next_list[i];
      seen[next_list[i]] = 1'b1;
    end
    or_count = n;
    if (w > seq_max_w) seq_max_w = w;
    if (last) begin
      hit_all = 1'b1;
      for (int unsigned k = 1; k <= m; k++) begin
        if (!seen[k]) begin
          hit_all = 1'b0;
          break;
        end
      end
      covered_q = {covered_q, hit_all};
      for (int k = 0; k < (1 << seq_max_w); k++) seen[k] = 1'b0;
      or_count = 0;
      seq_max_w = 0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg = WIDTH_RESET;
      or_count = 0;
      seq_max_w = 0;
      covered_q.delete();
    end else begin
      if (out_strobe) begin
        if (covered_q.size() == 0) begin
          flag_failure($sformatf("all_covered=%0d with no transaction pending",
                                 out_all_covered));
        end else if (covered_q[0] !== out_all_covered) begin
          flag_failure($sformatf("all_covered mismatch: expected %0d got %0d",
                                 covered_q[0], out_all_covered));
          void'(covered_q.pop_front());
        end else begin
          void'(covered_q.pop_front());
        end
      end
      // an item taken on the same edge as a write still uses the old width
      if (start && !busy) fold_mask(in_mask_value, in_last_item);
      if (cfg_we) width_reg = cfg_wdata;
    end
    outstanding = covered_q.size();
  end

endmodule

@@ verif/tb_subarray_or_coverage_check.sv @@
// Testbench top for subarray_or_coverage_check: clock, reset, width writes and mask
// sequences; checking is done by coverage_result_checker. Depends on socc_pkg.
module tb_subarray_or_coverage_check;
  import socc_pkg::*;

  localparam int LIST_DEPTH     = LIST_DEPTH_DEF;
  localparam int RANDOM_ITEMS   = 1400;
  // longest silent stretch is a full bitmap clear or sweep
  localparam int WATCHDOG_LIMIT = 200000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic [IN_W-1:0]  in_mask_value = '0;
  logic             in_last_item = 1'b0;
  logic             cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  wire              busy;
  wire              out_strobe;
  wire              out_all_covered;
  int               mismatches;
  int               outstanding;
  int               idle_pct = 0;
  int               items_sent = 0;
  int               quiet_cycles = 0;
  int               heavy_left = 2;

  subarray_or_coverage_check u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mask_value   (in_mask_value),
    .in_last_item    (in_last_item),
    .out_strobe      (out_strobe),
    .out_all_covered (out_all_covered),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  coverage_result_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mask_value   (in_mask_value),
    .in_last_item    (in_last_item),
    .out_strobe      (out_strobe),
    .out_all_covered (out_all_covered),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .mismatches      (mismatches),
    .outstanding     (outstanding)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Returns right after the edge that takes the transaction; start is touched
  // again only at the next falling edge.
  task automatic drive_item(input logic [IN_W-1:0] m, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      in_mask_value <= IN_W'($urandom);
      in_last_item <= 1'($urandom);
      @(negedge clk);
    end
    start <= 1'b1;
    in_mask_value <= m;
    in_last_item <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  // Pauses the sender until nothing is pending and the block is idle, then writes w.
  task automatic write_width(input logic [CFG_W-1:0] w);
    @(negedge clk);
    start <= 1'b0;
    while (outstanding != 0 || busy) @(negedge clk);
    repeat (LIST_DEPTH + 2) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= w;
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_wdata <= CFG_W'($urandom);
  endtask

  task automatic run_sequence(input logic [CFG_W-1:0] wcfg, input bit mid_change);
    int              eff;
    int              cut;
    int              j;
    logic [IN_W-1:0] lowmask;
    logic [IN_W-1:0] tmp;
    logic [IN_W-1:0] vals [$];
    eff = (wcfg == 0) ? 1 : ((wcfg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(wcfg));
    lowmask = IN_W'((1 << eff) - 1);
    write_width(wcfg);
    if (eff <= 5 && $urandom_range(99) < 70) begin
      // every nonzero mask once, shuffled; sometimes one dropped or a stray added
      for (int v = 1; v <= lowmask; v++) vals = {vals, IN_W'(v)};
      for (int i = vals.size() - 1; i > 0; i--) begin
        j = $urandom_range(i);
        tmp = vals[i];
        vals[i] = vals[j];
        vals[j] = tmp;
      end
      if ($urandom_range(3) == 0) vals.delete($urandom_range(vals.size() - 1));
      if ($urandom_range(3) == 0) vals.insert($urandom_range(vals.size()), IN_W'($urandom));
      if (vals.size() == 0) vals = {vals, IN_W'($urandom)};
    end else begin
      repeat ($urandom_range(1, 12)) vals = {vals, IN_W'($urandom)};
    end
    cut = mid_change ? $urandom_range(vals.size() - 1) : -1;
    foreach (vals[i]) begin
      if (i == cut) write_width(CFG_W'($urandom_range(1, 8)));
      if ($urandom_range(1)) vals[i] = vals[i] | (IN_W'($urandom) & ~lowmask);
      drive_item(vals[i], i == vals.size() - 1);
    end
  endtask

  initial begin
    int               base;
    int               r;
    logic [CFG_W-1:0] wcfg;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // directed: width extremes, out-of-range widths, covered and uncovered runs
    write_width(1);
    drive_item(16'hFFFF, 1'b1);
    write_width(0);
    drive_item(16'h0000, 1'b1);
    write_width(2);
    drive_item(16'h0001, 1'b0);
    drive_item(16'h0002, 1'b1);
    write_width(3);
    drive_item(16'h0001, 1'b0);
    drive_item(16'h0002, 1'b0);
    drive_item(16'h0004, 1'b1);
    for (int v = 1; v < 8; v++) drive_item(IN_W'(v), v == 7);
    // narrowing the width between items of one sequence
    write_width(4);
    drive_item(16'hF0F3, 1'b0);
    write_width(2);
    drive_item(16'h0004, 1'b0);
    drive_item(16'h0001, 1'b1);
    write_width(16);
    drive_item(16'hFFFF, 1'b0);
    drive_item(16'h8000, 1'b0);
    drive_item(16'h0000, 1'b1);
    write_width(31);
    drive_item(16'h1234, 1'b1);

    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      case ((items_sent - base) * 4 / RANDOM_ITEMS)
        0:       idle_pct = 0;
        1:       idle_pct = 58;
        2:       idle_pct = 0;
        default: idle_pct = 38;
      endcase
      r = $urandom_range(99);
      if (r < 4) wcfg = '0;
      else if (r < 10) wcfg = CFG_W'($urandom_range(7, 12));
      else if (r < 12 && heavy_left > 0) begin
        heavy_left--;
        wcfg = $urandom_range(1) ? CFG_W'(16) : CFG_W'($urandom_range(17, 31));
      end else wcfg = CFG_W'($urandom_range(1, 6));
      run_sequence(wcfg, wcfg <= 12 && $urandom_range(9) == 0);
    end

    @(negedge clk);
    start <= 1'b0;
    while (outstanding != 0 || busy) @(negedge clk);
    repeat (LIST_DEPTH + 4) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
